// ===== src/memory_category_usage_tracker_core_defines.svh =====
// Assertion macros for the memory category usage tracker.
// Included by the top level; no other dependencies.
`ifndef MEMORY_CATEGORY_USAGE_TRACKER_CORE_DEFINES_SVH
`define MEMORY_CATEGORY_USAGE_TRACKER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MCUT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define MCUT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mcut_pkg.sv =====
// Shared constants, codes and types for the memory category usage tracker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mcut_pkg;

    localparam int CATEGORIES = 8;
    localparam int CMD_W      = 2;
    localparam int CAT_W      = 4;
    localparam int CNT_W      = 64;
    localparam int STAT_W     = 2;
    localparam int IDX_W      = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;

    // category limit of eight, one bit wider than the four-bit category field
    localparam logic [CAT_W:0] CAT_LIMIT = (CAT_W + 1)'(CATEGORIES);

    localparam logic [CMD_W-1:0] CMD_RESERVE     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET_PEAKS = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOMEM   = 2'd2;

    typedef logic [CNT_W-1:0] cnt_t;

    // controller -> datapath strobes
    typedef struct packed {
        logic load;     // capture input transfer
        logic calc;     // evaluate command, register candidates
        logic commit;   // update counters, load output register
    } dp_cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        cnt_t              cat_live;
        cnt_t              cat_peak;
        cnt_t              tot_live;
        cnt_t              tot_peak;
    } result_t;

endpackage

`default_nettype wire

// ===== src/memory_category_usage_tracker_core.sv =====
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tuser: cmd; tdata: category, bytes
// m_*      out  m_tvalid/m_tready  tuser: status; tdata: category/total counts
//
// A command passes from transfer in to result in the output register through
// capture, add/subtract with overflow and underflow checks, then counter and
// peak update. The next command is taken in the cycle after the update.
// The update waits while the output register holds a result not yet taken.
// Reset clears all counters at once; no clearing pass.
// Top level of the usage tracker. Depends on mcut_pkg, mcut_ctrl, mcut_dp and
// the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "memory_category_usage_tracker_core_defines.svh"

module memory_category_usage_tracker_core
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [71:0]  s_tdata,   // [3:0] category, [67:4] bytes, [71:68] zero
    input  wire logic [1:0]   s_tuser,   // [1:0] cmd
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [255:0]      m_tdata,   // [63:0] cat_live, [127:64] cat_peak,
                                         // [191:128] tot_live, [255:192] tot_peak
    output logic [1:0]        m_tuser    // [1:0] status
);

    mcut_pkg::dp_cmd_t dp_cmd;
    mcut_pkg::result_t result;

    mcut_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .dp_cmd    (dp_cmd)
    );

    mcut_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .dp_cmd   (dp_cmd),
        .cmd      (s_tuser),
        .category (s_tdata[3:0]),
        .bytes    (s_tdata[67:4]),
        .result   (result)
    );

    assign m_tuser = result.status;
    assign m_tdata = {result.tot_peak, result.tot_live,
                      result.cat_peak, result.cat_live};

    // one command in flight at a time
    `MCUT_ASSERT_NXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready,
        "input taken while a command is in flight")

    // peaks never fall below live counts
    `MCUT_ASSERT_IMP(a_total_peak_ge_live, clk, rst_n, m_tvalid,
        result.tot_peak >= result.tot_live, "total peak below total live")

    `MCUT_ASSERT_IMP(a_cat_peak_ge_live, clk, rst_n, m_tvalid,
        result.cat_peak >= result.cat_live,
        "category peak below category live")

endmodule

`default_nettype wire

// ===== src/mcut_ctrl.sv =====
// Controller state machine of the usage tracker: input and output handshakes
// and datapath strobes. Depends on mcut_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcut_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output mcut_pkg::dp_cmd_t     dp_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CALC  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        dp_cmd.load   = 1'b0;
        dp_cmd.calc   = 1'b0;
        dp_cmd.commit = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    dp_cmd.load = 1'b1;
                    state_next  = S_CALC;
                end
            end
            S_CALC:
            begin
                dp_cmd.calc = 1'b1;
                state_next  = S_WRITE;
            end
            S_WRITE:
            begin
                // hold until the output register can take the result
                if (out_free)
                begin
                    dp_cmd.commit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (dp_cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/mcut_dp.sv =====
// Datapath of the usage tracker: per-category and total counters, the
// add/subtract stage, peak update and the output register. Depends on mcut_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcut_dp
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire mcut_pkg::dp_cmd_t            dp_cmd,
    input  wire logic [mcut_pkg::CMD_W-1:0]   cmd,
    input  wire logic [mcut_pkg::CAT_W-1:0]   category,
    input  wire mcut_pkg::cnt_t               bytes,
    output mcut_pkg::result_t                 result
);

    // captured input
    logic [mcut_pkg::CMD_W-1:0] cmd_reg;
    logic [mcut_pkg::CAT_W-1:0] cat_reg;
    mcut_pkg::cnt_t             bytes_reg;

    // counter state
    mcut_pkg::cnt_t live_reg [mcut_pkg::CATEGORIES];
    mcut_pkg::cnt_t peak_reg [mcut_pkg::CATEGORIES];
    mcut_pkg::cnt_t tot_live_reg;
    mcut_pkg::cnt_t tot_peak_reg;

    // calc stage results
    mcut_pkg::cnt_t                new_cat_reg;
    mcut_pkg::cnt_t                new_tot_reg;
    logic [mcut_pkg::STAT_W-1:0]   status_reg;
    logic                          upd_reg;
    logic                          rsv_reg;
    logic                          rstpk_reg;

    mcut_pkg::result_t             result_reg;

    logic                          cat_ok;
    logic [mcut_pkg::IDX_W-1:0]    idx;
    mcut_pkg::cnt_t                cur_live;
    mcut_pkg::cnt_t                cur_peak;
    logic [mcut_pkg::CNT_W:0]      sum_cat;
    logic [mcut_pkg::CNT_W:0]      sum_tot;
    logic                          bytes_zero;
    logic                          cat_short;
    logic                          tot_short;

    mcut_pkg::cnt_t                new_cat_next;
    mcut_pkg::cnt_t                new_tot_next;
    logic [mcut_pkg::STAT_W-1:0]   status_next;
    logic                          upd_next;

    logic                          raise_cat;
    logic                          raise_tot;
    mcut_pkg::result_t             result_next;

    assign cat_ok   = {1'b0, cat_reg} < mcut_pkg::CAT_LIMIT;
    assign idx      = cat_reg[mcut_pkg::IDX_W-1:0];
    assign cur_live = live_reg[idx];
    assign cur_peak = peak_reg[idx];

    assign sum_cat    = {1'b0, cur_live} + {1'b0, bytes_reg};
    assign sum_tot    = {1'b0, tot_live_reg} + {1'b0, bytes_reg};
    assign bytes_zero = (bytes_reg == '0);
    assign cat_short  = cur_live < bytes_reg;
    assign tot_short  = tot_live_reg < bytes_reg;

    // command evaluation; invalid category wins over zero bytes
    always_comb
    begin
        status_next  = mcut_pkg::STAT_OK;
        upd_next     = 1'b0;
        new_cat_next = sum_cat[mcut_pkg::CNT_W-1:0];
        new_tot_next = sum_tot[mcut_pkg::CNT_W-1:0];
        unique case (cmd_reg)
            mcut_pkg::CMD_RESERVE:
            begin
                if (!cat_ok)
                    status_next = mcut_pkg::STAT_INVALID;
                else if (bytes_zero)
                    status_next = mcut_pkg::STAT_OK;
                else if (sum_cat[mcut_pkg::CNT_W] || sum_tot[mcut_pkg::CNT_W])
                    status_next = mcut_pkg::STAT_NOMEM;
                else
                    upd_next = 1'b1;
            end
            mcut_pkg::CMD_RELEASE:
            begin
                new_cat_next = cur_live - bytes_reg;
                new_tot_next = tot_live_reg - bytes_reg;
                if (!cat_ok)
                    status_next = mcut_pkg::STAT_INVALID;
                else if (bytes_zero)
                    status_next = mcut_pkg::STAT_OK;
                else if (cat_short || tot_short)
                    status_next = mcut_pkg::STAT_INVALID;
                else
                    upd_next = 1'b1;
            end
            mcut_pkg::CMD_RESET_PEAKS:
            begin
                status_next = mcut_pkg::STAT_OK;
            end
            default:
            begin
                status_next = mcut_pkg::STAT_INVALID;
            end
        endcase
    end

    // values after the update, as they go out and into the counters
    assign raise_cat = upd_reg && rsv_reg && (cur_peak < new_cat_reg);
    assign raise_tot = upd_reg && rsv_reg && (tot_peak_reg < new_tot_reg);

    always_comb
    begin
        result_next.status   = status_reg;
        result_next.tot_live = upd_reg ? new_tot_reg : tot_live_reg;
        if (rstpk_reg)
            result_next.tot_peak = tot_live_reg;
        else if (raise_tot)
            result_next.tot_peak = new_tot_reg;
        else
            result_next.tot_peak = tot_peak_reg;
        result_next.cat_live = '0;
        result_next.cat_peak = '0;
        if (cat_ok)
        begin
            result_next.cat_live = upd_reg ? new_cat_reg : cur_live;
            if (rstpk_reg)
                result_next.cat_peak = cur_live;
            else if (raise_cat)
                result_next.cat_peak = new_cat_reg;
            else
                result_next.cat_peak = cur_peak;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            cmd_reg   <= cmd;
            cat_reg   <= category;
            bytes_reg <= bytes;
        end
        if (dp_cmd.calc)
        begin
            new_cat_reg <= new_cat_next;
            new_tot_reg <= new_tot_next;
            status_reg  <= status_next;
            upd_reg     <= upd_next;
            rsv_reg     <= (cmd_reg == mcut_pkg::CMD_RESERVE);
            rstpk_reg   <= (cmd_reg == mcut_pkg::CMD_RESET_PEAKS);
        end
        if (dp_cmd.commit)
            result_reg <= result_next;
    end

    // counter state, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mcut_pkg::CATEGORIES; i++)
            begin
                live_reg[i] <= '0;
                peak_reg[i] <= '0;
            end
            tot_live_reg <= '0;
            tot_peak_reg <= '0;
        end
        else if (dp_cmd.commit)
        begin
            for (int i = 0; i < mcut_pkg::CATEGORIES; i++)
            begin
                if (rstpk_reg)
                    peak_reg[i] <= live_reg[i];
                else if (raise_cat && (idx == mcut_pkg::IDX_W'(i)))
                    peak_reg[i] <= new_cat_reg;
                if (upd_reg && (idx == mcut_pkg::IDX_W'(i)))
                    live_reg[i] <= new_cat_reg;
            end
            if (upd_reg)
                tot_live_reg <= new_tot_reg;
            if (rstpk_reg)
                tot_peak_reg <= tot_live_reg;
            else if (raise_tot)
                tot_peak_reg <= new_tot_reg;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire
